// ===== sv/bf3_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bf3_pkg
// shared types and constants of the 3x3 box filter
// ----------------------------------------------------------------------------
package bf3_pkg;

   // line buffer geometry
   localparam int MAX_WIDTH = 1024;
   localparam int ADDR_W    = $clog2(MAX_WIDTH);
   localparam int WIDTH_W   = $clog2(MAX_WIDTH + 1);

   // field widths
   localparam int PIX_W = 8;
   localparam int ROW_W = 12;
   localparam int COL_W = 10;
   localparam int SUM_W = 12;

   // mean approximation: (sum * 28) >> 8
   localparam int MEAN_MUL   = 28;
   localparam int MEAN_SHIFT = 8;
   localparam int PROD_W     = SUM_W + 5;

   // queue between front and back
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // configuration registers
   localparam int CSR_DATA_W  = 12;
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 1'd1;
   localparam logic [WIDTH_W-1:0] WIDTH_RESET  = 11'd512;
   localparam logic [ROW_W-1:0]   HEIGHT_RESET = 12'd512;
   localparam logic [WIDTH_W-1:0] WIDTH_MIN    = 11'd3;
   localparam logic [ROW_W-1:0]   HEIGHT_MIN   = 12'd3;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             frame_start;
   } bf3_req_type;

   typedef struct packed {
      logic [PIX_W-1:0] filtered;
      logic [ROW_W-1:0] out_row;
      logic [COL_W-1:0] out_col;
      logic             frame_last;
   } bf3_rsp_type;

   // window sum with its position, as queued between front and back
   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic [ROW_W-1:0] out_row;
      logic [COL_W-1:0] out_col;
      logic             frame_last;
   } bf3_win_type;

   typedef struct packed {
      logic [Q_CNT_W-1:0] count;
      logic               valid;
   } bf3_qstat_type;

endpackage
`default_nettype wire

// ===== sv/bf3_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bf3_front
// accepts pixels, tracks position, line buffer and window, sums interior items
// ----------------------------------------------------------------------------
module bf3_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_push,
   output      logic                           req_full,
   input  wire bf3_pkg::bf3_req_type           req_item,
   input  wire logic                           csr_wr_en,
   input  wire logic [bf3_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [bf3_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire bf3_pkg::bf3_qstat_type         q_stat,
   output      logic                           q_push,
   output      bf3_pkg::bf3_win_type           q_data
);
   import bf3_pkg::*;

   logic [WIDTH_W-1:0] width_ff;
   logic [ROW_W-1:0]   height_ff;
   logic [WIDTH_W-1:0] w_eff;
   logic [ROW_W-1:0]   h_eff;

   logic [ROW_W-1:0]  row_ff, row_in;
   logic [ADDR_W-1:0] col_ff, col_in;

   logic              accept;
   logic [ROW_W-1:0]  r_cur;
   logic [WIDTH_W-1:0] c_cur;
   logic [WIDTH_W-1:0] c_nxt;
   logic [ROW_W-1:0]  r_nxt;
   logic [ADDR_W-1:0] addr;

   // stage b
   logic              b_valid_ff;
   logic [ADDR_W-1:0] b_addr_ff;
   logic [PIX_W-1:0]  b_pixel_ff;
   logic              b_interior_ff;
   logic [ROW_W-1:0]  b_row_ff;
   logic [COL_W-1:0]  b_col_ff;
   logic              b_last_ff;

   logic [2*PIX_W-1:0] line_mem_ff [MAX_WIDTH];
   logic [2*PIX_W-1:0] rd_data_ff;
   logic               fwd_valid_ff;
   logic [ADDR_W-1:0]  fwd_addr_ff;
   logic [2*PIX_W-1:0] fwd_data_ff;
   logic [2*PIX_W-1:0] col_data;
   logic [PIX_W-1:0]   top;
   logic [PIX_W-1:0]   mid;

   logic [PIX_W-1:0] win_ff [3][3];
   logic [SUM_W-1:0] sum;

   logic [Q_CNT_W:0] q_used;

   // effective geometry
   always_comb begin
      if (width_ff < WIDTH_MIN) begin
         w_eff = WIDTH_MIN;
      end else if (width_ff > WIDTH_W'(MAX_WIDTH)) begin
         w_eff = WIDTH_W'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      h_eff = (height_ff < HEIGHT_MIN) ? HEIGHT_MIN : height_ff;
   end

   // room for this item and the one in stage b
   assign q_used   = {1'b0, q_stat.count} + {{Q_CNT_W{1'b0}}, b_valid_ff};
   assign req_full = q_used >= (Q_CNT_W + 1)'(Q_DEPTH);
   assign accept   = req_push && !req_full;

   // position of this item and of the next one
   always_comb begin
      r_cur = row_ff;
      c_cur = {1'b0, col_ff};
      if (req_item.frame_start) begin
         r_cur = '0;
         c_cur = '0;
      end else if (c_cur >= w_eff) begin
         c_cur = '0;
         r_cur = row_ff + 1'b1;
      end
      if (r_cur >= h_eff) begin
         r_cur = '0;
      end
      addr  = c_cur[ADDR_W-1:0];
      c_nxt = c_cur + 1'b1;
      r_nxt = r_cur;
      if (c_nxt >= w_eff) begin
         c_nxt = '0;
         r_nxt = r_cur + 1'b1;
         if (r_nxt >= h_eff) begin
            r_nxt = '0;
         end
      end
      col_in = c_nxt[ADDR_W-1:0];
      row_in = r_nxt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         row_ff       <= '0;
         col_ff       <= '0;
         b_valid_ff   <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[WIDTH_W-1:0];
               CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[ROW_W-1:0];
               default: ;
            endcase
         end
         if (accept) begin
            row_ff <= row_in;
            col_ff <= col_in;
         end
         b_valid_ff   <= accept;
         fwd_valid_ff <= b_valid_ff;
      end
   end

   // stage b payload
   always_ff @(posedge clock) begin
      if (accept) begin
         b_addr_ff     <= addr;
         b_pixel_ff    <= req_item.pixel;
         b_interior_ff <= (r_cur >= ROW_W'(2)) && (c_cur >= WIDTH_W'(2));
         b_row_ff      <= r_cur - 1'b1;
         b_col_ff      <= COL_W'(c_cur - 1'b1);
         b_last_ff     <= (r_cur == h_eff - 1'b1) && (c_cur == w_eff - 1'b1);
      end
   end

   // line buffer: each entry holds {two rows above, row above}
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff <= line_mem_ff[addr];
      end
      if (b_valid_ff) begin
         line_mem_ff[b_addr_ff] <= {mid, b_pixel_ff};
      end
   end

   // bypass the write of the item just before when it hit the same column
   always_ff @(posedge clock) begin
      fwd_addr_ff <= b_addr_ff;
      fwd_data_ff <= {mid, b_pixel_ff};
   end

   assign col_data = (fwd_valid_ff && (fwd_addr_ff == b_addr_ff)) ? fwd_data_ff : rd_data_ff;
   assign top      = col_data[2*PIX_W-1:PIX_W];
   assign mid      = col_data[PIX_W-1:0];

   // window shifts left by one column per item
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else if (b_valid_ff) begin
         for (int i = 0; i < 3; i++) begin
            win_ff[i][0] <= win_ff[i][1];
            win_ff[i][1] <= win_ff[i][2];
         end
         win_ff[0][2] <= top;
         win_ff[1][2] <= mid;
         win_ff[2][2] <= b_pixel_ff;
      end
   end

   always_comb begin
      sum = SUM_W'(top) + SUM_W'(mid) + SUM_W'(b_pixel_ff);
      for (int i = 0; i < 3; i++) begin
         sum = sum + SUM_W'(win_ff[i][1]) + SUM_W'(win_ff[i][2]);
      end
   end

   assign q_push            = b_valid_ff && b_interior_ff;
   assign q_data.sum        = sum;
   assign q_data.out_row    = b_row_ff;
   assign q_data.out_col    = b_col_ff;
   assign q_data.frame_last = b_last_ff;

endmodule
`default_nettype wire

// ===== sv/bf3_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bf3_queue
// short queue of window sums between front and back
// ----------------------------------------------------------------------------
module bf3_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire bf3_pkg::bf3_win_type   push_data,
   input  wire logic                   pop,
   output      bf3_pkg::bf3_win_type   head_data,
   output      bf3_pkg::bf3_qstat_type stat
);
   import bf3_pkg::*;

   bf3_win_type        entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff;
   logic [Q_PTR_W-1:0] rd_ptr_ff;
   logic [Q_CNT_W-1:0] count_ff;
   logic               do_pop;

   assign do_pop     = pop && (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign stat.count = count_ff;
   assign stat.valid = count_ff != '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (!push && do_pop) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ===== sv/bf3_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bf3_back
// scales the window sum to the mean and holds the result item
// ----------------------------------------------------------------------------
module bf3_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire bf3_pkg::bf3_qstat_type q_stat,
   input  wire bf3_pkg::bf3_win_type   q_head,
   output      logic                   q_pop,
   output      logic                   rsp_empty,
   input  wire logic                   rsp_pop,
   output      bf3_pkg::bf3_rsp_type   rsp_item
);
   import bf3_pkg::*;

   logic              out_valid_ff;
   bf3_rsp_type       out_ff;
   logic [PROD_W-1:0] prod;

   assign prod  = PROD_W'(q_head.sum) * PROD_W'(MEAN_MUL);
   assign q_pop = q_stat.valid && (!out_valid_ff || rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (q_pop) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         out_ff.filtered   <= prod[MEAN_SHIFT +: PIX_W];
         out_ff.out_row    <= q_head.out_row;
         out_ff.out_col    <= q_head.out_col;
         out_ff.frame_last <= q_head.frame_last;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_item  = out_ff;

endmodule
`default_nettype wire

// ===== sv/box_filter_3x3.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// box_filter_3x3
// streaming 3x3 mean filter for 8-bit grayscale pixels in raster order
// ----------------------------------------------------------------------------
// usage
//   input side looks like a queue: drive req_item and raise req_push; the
//   item is taken at a clock edge with req_push high and req_full low
//   result side looks like a queue: while rsp_empty is low the oldest result
//   is on rsp_item; raise rsp_pop to take it
//   csr port: csr_wr_en with csr_index 0 (image_width) or 1 (image_height)
//   writes csr_wdata at the edge; write only while the block is idle
// timing
//   one item per clock sustained while req_full is low; an interior item's
//   result shows on rsp_item after stage b (line buffer read and sum), the
//   queue and then the output register
//   border pixels give no result
//   the line buffer is a single-port-write memory of MAX_WIDTH entries of two
//   pixels, read as an item is taken and written from stage b for that item
// reset
//   synchronous; counters at row 0 column 0, window cleared, registers at 512
// stalls
//   a four-entry queue sits between the front and the back; with the receiver
//   stalled and the output register held, req_full rises once the queue and
//   the item in the window stage together reach four
// ----------------------------------------------------------------------------
module box_filter_3x3 (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_push,
   output      logic                            req_full,
   input  wire bf3_pkg::bf3_req_type            req_item,
   output      logic                            rsp_empty,
   input  wire logic                            rsp_pop,
   output      bf3_pkg::bf3_rsp_type            rsp_item,
   input  wire logic                            csr_wr_en,
   input  wire logic [bf3_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [bf3_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import bf3_pkg::*;

   // front to queue
   logic          q_push;
   bf3_win_type   q_push_data;
   // queue to back
   logic          q_pop;
   bf3_win_type   q_head;
   bf3_qstat_type q_stat;

   // position tracking, line buffer, window and sum
   bf3_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_item  (req_item),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_stat    (q_stat),
      .q_push    (q_push),
      .q_data    (q_push_data)
   );

   // decouples the front from a stalling receiver
   bf3_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .head_data (q_head),
      .stat      (q_stat)
   );

   // mean scaling and output register
   bf3_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

endmodule
`default_nettype wire
